/* rtl/core/tksel_pkg.sv */
// Shared types, constants and the float ordering function for the top-k selector.
// No dependencies.
package tksel_pkg;

   localparam int VALUE_W    = 32;
   localparam int POS_W      = 10;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_TOP_COUNT  = 2'd0,
      REG_ROW_LENGTH = 2'd1,
      REG_ROW_TOTAL  = 2'd2,
      REG_NONE       = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;
      logic               valid;
   } entry_type;

   typedef struct packed {
      logic ins;
      logic shift;
      logic clear;
   } chain_ctrl_type;

   // unsigned key whose order is the IEEE order; both zeros map alike
   function automatic logic [VALUE_W-1:0] order_key(input logic [VALUE_W-1:0] b);
      logic [VALUE_W-1:0] k;
      if (b[VALUE_W-2:0] == '0) begin
         k = {1'b1, {(VALUE_W-1){1'b0}}};
      end else if (b[VALUE_W-1]) begin
         k = ~b;
      end else begin
         k = {1'b1, b[VALUE_W-2:0]};
      end
      return k;
   endfunction

endpackage

/* rtl/core/tksel_cell.sv */
// One slot of the sorted insertion chain: holds a value, its position and a valid flag.
// Depends on tksel_pkg.
module tksel_cell
   import tksel_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  chain_ctrl_type      ctrl,
   input  logic                active,
   input  entry_type           new_ent,
   input  logic [VALUE_W-1:0]  new_key,
   input  entry_type           up_ent,
   input  logic                up_keep,
   input  entry_type           dn_ent,
   output entry_type           ent,
   output logic                keep
);

   logic [VALUE_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               valid_ff, valid_in;

   assign ent  = '{value: value_ff, pos: pos_ff, valid: valid_ff};
   // stored entry ranks at or above the incoming one: it stays put
   assign keep = valid_ff && (order_key(value_ff) >= new_key);

   always_comb begin
      value_in = value_ff;
      pos_in   = pos_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.ins) begin
         if (active && !keep) begin
            if (up_keep) begin
               value_in = new_ent.value;
               pos_in   = new_ent.pos;
               valid_in = 1'b1;
            end else begin
               value_in = up_ent.value;
               pos_in   = up_ent.pos;
               valid_in = up_ent.valid;
            end
         end
      end else if (ctrl.shift) begin
         value_in = dn_ent.value;
         pos_in   = dn_ent.pos;
         valid_in = dn_ent.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      pos_ff   <= pos_in;
   end

endmodule

/* rtl/core/tksel_chain.sv */
// Row of insertion cells; inserts one request per cycle, drains from the head.
// Depends on tksel_pkg and tksel_cell.
module tksel_chain
   import tksel_pkg::*;
#(
   parameter int MAX_K = 16,
   parameter int KW    = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  chain_ctrl_type      ctrl,
   input  logic [KW-1:0]       kc,
   input  entry_type           new_ent,
   output entry_type           head
);

   entry_type          ent  [MAX_K];
   logic               keep [MAX_K];
   logic [VALUE_W-1:0] new_key;

   assign new_key = order_key(new_ent.value);
   assign head    = ent[0];

   for (genvar i = 0; i < MAX_K; i++) begin : g_cell
      localparam logic [KW-1:0] IDX = KW'(i);
      entry_type up_ent;
      entry_type dn_ent;
      logic      up_keep;

      if (i == 0) begin : g_first
         assign up_ent  = new_ent;
         assign up_keep = 1'b1;
      end else begin : g_mid
         assign up_ent  = ent[i-1];
         assign up_keep = keep[i-1];
      end

      if (i == MAX_K - 1) begin : g_last
         assign dn_ent = '0;
      end else begin : g_inner
         assign dn_ent = ent[i+1];
      end

      tksel_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .active  (IDX < kc),
         .new_ent (new_ent),
         .new_key (new_key),
         .up_ent  (up_ent),
         .up_keep (up_keep),
         .dn_ent  (dn_ent),
         .ent     (ent[i]),
         .keep    (keep[i])
      );
   end

endmodule

/* rtl/core/top_k_select_with_index_unit.sv */
// Top-k selector with positions: config registers, row control, drain and output stage.
// Depends on tksel_pkg and tksel_chain.
//
// Request channel (req_*): one IEEE single value per request, rows of row_length values.
// Each request is inserted into a sorted chain of cells, so values are taken one per
// cycle within a row. After the last value of a row the chain is drained from its head,
// one pair per cycle while the response is not stalled: the drain flag is registered
// first, then the head pair passes through the output register onto rsp_*. req_tready
// stays low while the chain drains.
// Response channel (rsp_*): k pairs per row, largest first, earlier position first on
// ties; rsp_tlast marks the last pair of a row, rsp_tuser the last pair of the run.
// A stalled response holds in the output register and pauses the drain; the next
// request is taken as soon as the last pair of a row sits in that register.
// CSR port: top_count at 0x0, row_length at 0x4, row_total at 0x8. Any write to them
// restarts the run; the user must write only while the block is idle; not enforced.
// Reset loads the register defaults (k 1, row 1024, 1 row per run) and empties the
// chain at once; no clearing pass is needed.
module top_k_select_with_index_unit
   import tksel_pkg::*;
#(
   parameter int MAX_K   = 16,
   parameter int MAX_ROW = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   // sample_bits[31:0]
   input  logic [VALUE_W-1:0]     req_tdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // ranked_bits[31:0], position[41:32], zero[47:42]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // run_end
   output logic                   rsp_tuser,
   output logic                   rsp_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int KW = $clog2(MAX_K + 1);
   localparam int CW = $clog2(MAX_ROW);

   // config registers
   logic [4:0]  top_count_ff, top_count_in;
   logic [10:0] row_length_ff, row_length_in;
   logic [15:0] row_total_ff, row_total_in;
   logic        cfg_wr;
   reg_index_type cfg_idx;

   // row control
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   row_ff, row_in;
   logic          draining_ff, draining_in;
   logic [KW-1:0] left_ff, left_in;
   logic          last_row_ff, last_row_in;

   // output stage
   logic [VALUE_W-1:0] out_value_ff, out_value_in;
   logic [POS_W-1:0]   out_pos_ff, out_pos_in;
   logic               out_last_ff, out_last_in;
   logic               out_run_ff, out_run_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [KW-1:0]       kc;
   logic [CW-1:0]       row_last;
   logic [15:0]         rt_last;
   logic                acc, row_done, drain_step, cfg_restart;
   logic [CW+POS_W-1:0] count_wide;
   entry_type           new_ent, head;
   chain_ctrl_type      ctrl;

   assign csr_pready = 1'b1;
   assign cfg_idx    = reg_index_type'(csr_paddr[3:2]);
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      unique case (cfg_idx)
         REG_TOP_COUNT:  csr_prdata = {27'd0, top_count_ff};
         REG_ROW_LENGTH: csr_prdata = {21'd0, row_length_ff};
         REG_ROW_TOTAL:  csr_prdata = {16'd0, row_total_ff};
         default:        csr_prdata = '0;
      endcase
   end

   always_comb begin
      top_count_in  = top_count_ff;
      row_length_in = row_length_ff;
      row_total_in  = row_total_ff;
      cfg_restart   = 1'b0;
      if (cfg_wr) begin
         unique case (cfg_idx)
            REG_TOP_COUNT: begin
               top_count_in = csr_pwdata[4:0];
               cfg_restart  = 1'b1;
            end
            REG_ROW_LENGTH: begin
               row_length_in = csr_pwdata[10:0];
               cfg_restart   = 1'b1;
            end
            REG_ROW_TOTAL: begin
               row_total_in = csr_pwdata[15:0];
               cfg_restart  = 1'b1;
            end
            default: cfg_restart = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_count_ff  <= 5'd1;
         row_length_ff <= 11'd1024;
         row_total_ff  <= 16'd1;
      end else begin
         top_count_ff  <= top_count_in;
         row_length_ff <= row_length_in;
         row_total_ff  <= row_total_in;
      end
   end

   // effective k, row length and row count
   always_comb begin
      int r;
      int k;
      r = int'(row_length_ff);
      if (r == 0) r = 1;
      if (r > MAX_ROW) r = MAX_ROW;
      k = int'(top_count_ff);
      if (k == 0) k = 1;
      if (k > MAX_K) k = MAX_K;
      if (k > r) k = r;
      kc       = KW'(k);
      row_last = CW'(r - 1);
      rt_last  = (row_total_ff == 16'd0) ? 16'd0 : row_total_ff - 16'd1;
   end

   assign req_tready = !draining_ff;
   assign acc        = req_tvalid && req_tready;
   assign row_done   = acc && (count_ff == row_last);
   assign drain_step = draining_ff && (!rsp_valid_ff || rsp_tready);

   assign count_wide = {{POS_W{1'b0}}, count_ff};
   assign new_ent    = '{value: req_tdata, pos: count_wide[POS_W-1:0], valid: 1'b1};

   assign ctrl.ins   = acc;
   assign ctrl.shift = drain_step;
   assign ctrl.clear = cfg_restart || (drain_step && left_ff == KW'(1));

   tksel_chain #(
      .MAX_K (MAX_K),
      .KW    (KW)
   ) u_chain (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .kc      (kc),
      .new_ent (new_ent),
      .head    (head)
   );

   always_comb begin
      count_in     = count_ff;
      row_in       = row_ff;
      draining_in  = draining_ff;
      left_in      = left_ff;
      last_row_in  = last_row_ff;
      out_value_in = out_value_ff;
      out_pos_in   = out_pos_ff;
      out_last_in  = out_last_ff;
      out_run_in   = out_run_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cfg_restart) begin
         count_in = '0;
         row_in   = '0;
      end else if (acc) begin
         if (row_done) begin
            count_in    = '0;
            draining_in = 1'b1;
            left_in     = kc;
            last_row_in = (row_ff >= rt_last);
            row_in      = (row_ff >= rt_last) ? 16'd0 : row_ff + 16'd1;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end
      if (drain_step) begin
         out_value_in = head.value;
         out_pos_in   = head.pos;
         out_last_in  = (left_ff == KW'(1));
         out_run_in   = (left_ff == KW'(1)) && last_row_ff;
         rsp_valid_in = 1'b1;
         left_in      = left_ff - KW'(1);
         if (left_ff == KW'(1)) begin
            draining_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         row_ff       <= '0;
         draining_ff  <= 1'b0;
         left_ff      <= '0;
         last_row_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         row_ff       <= row_in;
         draining_ff  <= draining_in;
         left_ff      <= left_in;
         last_row_ff  <= last_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      out_pos_ff   <= out_pos_in;
      out_last_ff  <= out_last_in;
      out_run_ff   <= out_run_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-VALUE_W-POS_W){1'b0}}, out_pos_ff, out_value_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_run_ff;

`ifndef SYNTHESIS
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      drain_step |-> head.valid)
      else $error("drained an empty cell");

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      draining_ff |-> (left_ff != '0) && (left_ff <= kc))
      else $error("drain count out of range");

   a_row_close: assert property (@(posedge clock) disable iff (reset)
      drain_step && (left_ff == KW'(1)) |=> rsp_tvalid && rsp_tlast && !draining_ff)
      else $error("row not closed with tlast");

   a_drain_start: assert property (@(posedge clock) disable iff (reset)
      row_done |=> draining_ff && (left_ff == $past(kc)))
      else $error("drain not started at row end");
`endif

endmodule

/* dv/top_k_select_with_index_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the top-k selector: follows CSR writes and accepted requests,
// predicts the ranked pairs of each row and checks them against the response stream.
// Depends on tksel_pkg.
module topk_rank_checker
   import tksel_pkg::*;
#(
   parameter int MAX_K   = 16,
   parameter int MAX_ROW = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [VALUE_W-1:0]     req_tdata,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   rsp_tuser,
   input  logic                   rsp_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                   csr_pready,
   output int                     fail_count,
   output int                     pending
);

   typedef struct packed {
      logic [VALUE_W-1:0] bits;
      logic [POS_W-1:0]   pos;
      logic               row_end;
      logic               run_end;
   } ranked_pair_type;

   logic [4:0]         top_count;
   logic [10:0]        row_length;
   logic [15:0]        row_total;
   logic [VALUE_W-1:0] best_bits  [MAX_K];
   logic [10:0]        best_pos   [MAX_K];
   logic               best_valid [MAX_K];
   int unsigned        filled;
   int unsigned        rows_done;
   ranked_pair_type    pairs_due [$];

   // sign-magnitude float to an unsigned key in IEEE order, both zeros equal
   function automatic logic [31:0] ieee_rank(input logic [31:0] bits);
      if (bits[30:0] == 31'd0) return 32'h8000_0000;
      return bits[31] ? ~bits : {1'b1, bits[30:0]};
   endfunction

   function automatic int unsigned eff_row_len();
      int unsigned r;
      r = (row_length == 0) ? 1 : row_length;
      return (r > MAX_ROW) ? MAX_ROW : r;
   endfunction

   function automatic int unsigned keep_count();
      int unsigned k;
      k = (top_count == 0) ? 1 : top_count;
      if (k > MAX_K) k = MAX_K;
      if (k > eff_row_len()) k = eff_row_len();
      return k;
   endfunction

   task automatic clear_kept();
      for (int i = 0; i < MAX_K; i++) best_valid[i] = 1'b0;
      filled = 0;
   endtask

   task automatic apply_setting(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] data);
      case (reg_index_type'(idx))
         REG_TOP_COUNT:  top_count  = data[4:0];
         REG_ROW_LENGTH: row_length = data[10:0];
         REG_ROW_TOTAL:  row_total  = data[15:0];
         default: ;
      endcase
      if (reg_index_type'(idx) != REG_NONE) begin
         clear_kept();
         rows_done = 0;
      end
   endtask

   task automatic insert_sample(input logic [VALUE_W-1:0] bits);
      int unsigned     kc;
      int unsigned     rt;
      int unsigned     slot;
      logic [31:0]     key;
      bit              last_row;
      ranked_pair_type pair;
      kc = keep_count();
      rt = (row_total == 0) ? 1 : row_total;
      key = ieee_rank(bits);
      slot = 0;
      // equal keys stay ahead: earlier position ranks first
      while (slot < kc && best_valid[slot] && ieee_rank(best_bits[slot]) >= key) slot++;
      if (slot < kc) begin
         for (int i = kc - 1; i > slot; i--) begin
            best_bits[i]  = best_bits[i-1];
            best_pos[i]   = best_pos[i-1];
            best_valid[i] = best_valid[i-1];
         end
         best_bits[slot]  = bits;
         best_pos[slot]   = 11'(filled);
         best_valid[slot] = 1'b1;
      end
      filled++;
      if (filled >= eff_row_len()) begin
         last_row = (rows_done + 1 >= rt);
         for (int i = 0; i < kc; i++) begin
            pair.bits    = best_bits[i];
            pair.pos     = best_pos[i][POS_W-1:0];
            pair.row_end = (i + 1 == kc);
            pair.run_end = pair.row_end && last_row;
            pairs_due    = {pairs_due, pair};
         end
         clear_kept();
         rows_done = last_row ? 0 : rows_done + 1;
      end
   endtask

   task automatic check_pair();
      ranked_pair_type want;
      ranked_pair_type got;
      got = {rsp_tdata[31:0], rsp_tdata[41:32], rsp_tlast, rsp_tuser};
      if (pairs_due.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: unexpected pair bits=%h pos=%0d last=%b run_end=%b",
                     $realtime, got.bits, got.pos, got.row_end, got.run_end);
      end else begin
         want = pairs_due.pop_front();
         if (got.bits !== want.bits || got.pos !== want.pos ||
             got.row_end !== want.row_end || got.run_end !== want.run_end) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: pair mismatch exp bits=%h pos=%0d last=%b run_end=%b,",
                        $realtime, want.bits, want.pos, want.row_end, want.run_end,
                        " got bits=%h pos=%0d last=%b run_end=%b",
                        got.bits, got.pos, got.row_end, got.run_end);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         top_count  = 5'd1;
         row_length = 11'd1024;
         row_total  = 16'd1;
         clear_kept();
         rows_done = 0;
         pairs_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_pair();
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            apply_setting(csr_paddr[3:2], csr_pwdata);
         if (req_tvalid && req_tready) insert_sample(req_tdata);
      end
      pending = pairs_due.size();
   end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Top of the top-k selector testbench: clock, reset, request and CSR stimulus, response
// backpressure, watchdog and verdict. Uses tksel_pkg, topk_rank_checker and the selector.
module tb;
   import tksel_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 20;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic [VALUE_W-1:0]    req_tdata   = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    pending;

   int          send_idle_pct = 10;
   int          recv_idle_pct = 88;
   int          sent_total    = 0;
   int          quiet         = 0;
   logic [31:0] tie_pool [4];

   top_k_select_with_index_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   topk_rank_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet = 0;
      end else begin
         quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [31:0] special_value(input int unsigned n);
      case (n)
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return 32'h7F80_0000;
         3: return 32'hFF80_0000;
         4: return 32'h7FC0_0000;
         5: return 32'hFFC0_0000;
         6: return 32'h7F7F_FFFF;
         7: return 32'hFF7F_FFFF;
         8: return 32'h0000_0001;
         default: return 32'h8000_0001;
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel < 5) return $urandom();
      if (sel < 7) return special_value($urandom_range(9));
      return tie_pool[$urandom_range(3)];
   endfunction

   task automatic send_value(input logic [31:0] v);
      sent_total++;
      if (sent_total < 90) begin
         send_idle_pct = 10;
         recv_idle_pct = 88;
      end else if (sent_total < 170) begin
         send_idle_pct = 88;
         recv_idle_pct = 10;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = v;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_row(input int unsigned n);
      for (int i = 0; i < 4; i++) tie_pool[i] = $urandom();
      for (int unsigned i = 0; i < n; i++) send_value(pick_value());
   endtask

   task automatic drain_all();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // block idle before a CSR write
   task automatic settle();
      drain_all();
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   initial begin
      int unsigned k;
      int unsigned len;
      int unsigned rows;
      int unsigned eff_len;
      int          random_end;

      repeat (3) @(negedge clock);
      reset = 1'b0;

      // signed zeros tie, NaNs rank outside the infinities
      write_reg(REG_TOP_COUNT, 32'd3);
      write_reg(REG_ROW_LENGTH, 32'd4);
      write_reg(REG_ROW_TOTAL, 32'd3);
      send_value(32'h8000_0000);
      send_value(32'h0000_0000);
      send_value(32'hFF80_0000);
      send_value(32'h7FFF_FFFF);
      send_value(32'hFFFF_FFFF);
      send_value(32'h7F7F_FFFF);
      send_value(32'h0000_0001);
      send_value(32'h8000_0001);
      // write to an unmapped index must not restart the run
      settle();
      write_reg(REG_NONE, 32'd5);
      send_value(32'h3F80_0000);
      send_value(32'h3F80_0000);
      send_value(32'hC000_0000);
      send_value(32'h7F80_0000);

      // zero and oversized settings clamp
      settle();
      write_reg(REG_ROW_LENGTH, 32'd0);
      write_reg(REG_TOP_COUNT, 32'd0);
      send_value(32'hBF80_0000);
      settle();
      write_reg(REG_TOP_COUNT, 32'd31);
      write_reg(REG_ROW_TOTAL, 32'd0);
      send_value(32'h0080_0000);
      send_value(32'hFF7F_FFFF);

      // ties, then restart in the middle of a row
      settle();
      write_reg(REG_TOP_COUNT, 32'd2);
      write_reg(REG_ROW_LENGTH, 32'd2);
      write_reg(REG_ROW_TOTAL, 32'd65535);
      send_value(32'h4049_0FDB);
      send_value(32'h4049_0FDB);
      send_value(32'h1234_5678);
      settle();
      write_reg(REG_ROW_TOTAL, 32'd2);
      send_value(32'hC049_0FDB);
      send_value(32'h8000_0000);
      send_value(32'h0000_0000);
      send_value(32'h7FC0_0001);

      random_end = sent_total + 180;
      while (sent_total < random_end) begin
         settle();
         k = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(1, 16);
         case ($urandom_range(9))
            0:       len = 0;
            1:       len = $urandom_range(13, 48);
            default: len = $urandom_range(1, 12);
         endcase
         eff_len = (len == 0) ? 1 : len;
         write_reg(REG_TOP_COUNT, k | ($urandom_range(1) ? ($urandom() << 5) : 0));
         write_reg(REG_ROW_LENGTH, len | ($urandom_range(1) ? ($urandom() << 11) : 0));
         write_reg(REG_ROW_TOTAL, $urandom_range(4) | ($urandom_range(3) == 0 ?
                                                       ($urandom() << 16) : 0));
         rows = $urandom_range(1, 5);
         for (int unsigned r = 0; r < rows; r++) begin
            if (r + 1 == rows && $urandom_range(7) == 0)
               send_row($urandom_range(eff_len - 1));
            else
               send_row(eff_len);
            if ($urandom_range(4) == 0) drain_all();
         end
      end

      // oversized row length and k clamp; the row stays open, nothing comes out
      settle();
      write_reg(REG_TOP_COUNT, 32'd31);
      write_reg(REG_ROW_LENGTH, 32'd2047);
      write_reg(REG_ROW_TOTAL, 32'd1);
      send_row(12);

      drain_all();
      repeat (DRAIN_WAIT) @(negedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
